/* rtl/mmffc_pkg.sv */
// shared types and constants for the memory map first-fit carver
`timescale 1ns / 1ps
`default_nettype none

package mmffc_pkg;

    // region table size
    localparam int MAX_REGIONS = 128;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CTR_W       = $clog2(MAX_REGIONS + 1);

    // fixed field widths
    localparam int CMD_W      = 1;
    localparam int SLOT_W     = 7;
    localparam int ADDR_W     = 64;
    localparam int KIND_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // common widths for slot and count compares
    localparam int CMP_W  = (CNT_W > CTR_W) ? CNT_W : CTR_W;
    localparam int LOAD_W = (SLOT_W > CTR_W) ? SLOT_W : CTR_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_TYPE    = 1'b1;

    localparam logic [KIND_W-1:0] RAM_TYPE_RESET = 32'd1;

    // one region table word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] base;
    } t_region;

endpackage

`default_nettype wire

/* rtl/mmffc_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mmffc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/memory_map_first_fit_carver.sv */
// top level of the memory map first-fit carver: sequencer, shared adder and region table
`timescale 1ns / 1ps
`default_nettype none

// First-fit carver over a table of up to 128 memory regions (base, length,
// type), held in one ram. A load transfer writes one slot and its result is
// ready in the next cycle; loads to a slot past the table size answer status 0
// without writing. An allocate transfer scans slots 0 .. entry_count-1
// (clamped to the table size) one slot per cycle through the ram read port,
// and takes the first slot whose type equals ram_type_code and whose length
// is at least request_size. One 65-bit adder does both the length compare
// during the scan and the base update afterwards. A hit goes from the scan
// to the write-back state, which writes the carved slot back and registers
// the grant; a miss registers out of memory once the clamped count of slots
// has been scanned. The block takes no new transfer during a scan or
// write-back; when idle it takes one whenever the output register is empty
// or its result leaves in that same cycle. Configuration writes land at
// once and must come while the block is idle. Scanning a slot never loaded
// since reset gives undefined results.

module memory_map_first_fit_carver (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [mmffc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mmffc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [mmffc_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [mmffc_pkg::SLOT_W-1:0]        i_entry_index,
    input  wire logic [mmffc_pkg::ADDR_W-1:0]        i_entry_base,
    input  wire logic [mmffc_pkg::ADDR_W-1:0]        i_entry_length,
    input  wire logic [mmffc_pkg::KIND_W-1:0]        i_entry_type,
    input  wire logic [mmffc_pkg::ADDR_W-1:0]        i_request_size,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [mmffc_pkg::STATUS_W-1:0]      o_status,
    output logic      [mmffc_pkg::ADDR_W-1:0]        o_granted_address,
    output logic      [mmffc_pkg::SLOT_W-1:0]        o_granted_slot
);

    import mmffc_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    // control state
    logic [1:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic                r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]    r_entry_count;
    logic [KIND_W-1:0]   r_ram_type;

    // payload state
    logic [CTR_W-1:0]    r_rd_idx, n_rd_idx;     // next slot to read
    logic [CTR_W-1:0]    r_chk_idx, n_chk_idx;   // slot whose data is on the ram output
    logic [ADDR_W-1:0]   r_size, n_size;
    logic [ADDR_W-1:0]   r_old_base, n_old_base;
    logic [ADDR_W-1:0]   r_new_len, n_new_len;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SLOT_W-1:0]   r_slot, n_slot;

    // ram port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_region             ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [$bits(t_region)-1:0] ram_rdata;
    t_region             rd_region;

    // shared adder
    logic [ADDR_W-1:0]   add_a, add_b;
    logic                add_cin;
    logic [ADDR_W:0]     add_sum;

    logic                in_xfer;
    logic [CMP_W-1:0]    limit;
    logic                scan_end;
    logic                hit;
    logic                load_in_range;

    mmffc_ram #(
        .WIDTH ($bits(t_region)),
        .DEPTH (MAX_REGIONS)
    ) u_region_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_region = t_region'(ram_rdata);

    // request accepted only when idle and the output slot is free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;

    // scan limit is the count clamped to the table size
    assign limit = (CMP_W'(r_entry_count) > CMP_W'(MAX_REGIONS)) ?
                   CMP_W'(MAX_REGIONS) : CMP_W'(r_entry_count);
    assign scan_end = (CMP_W'(r_rd_idx) >= limit);

    assign load_in_range = (LOAD_W'(i_entry_index) < LOAD_W'(MAX_REGIONS));

    // scan: length - size, carry out means no borrow; write-back: base + size
    always_comb begin
        if (r_state == S_WRITE) begin
            add_a   = r_old_base;
            add_b   = r_size;
            add_cin = 1'b0;
        end else begin
            add_a   = rd_region.length;
            add_b   = ~r_size;
            add_cin = 1'b1;
        end
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (ADDR_W + 1)'(add_cin);

    assign hit = (r_state == S_SCAN) && r_chk_vld &&
                 (rd_region.kind == r_ram_type) && add_sum[ADDR_W];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_size      = r_size;
        n_old_base  = r_old_base;
        n_new_len   = r_new_len;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_addr      = r_addr;
        n_slot      = r_slot;

        ram_we           = 1'b0;
        ram_waddr        = IDX_W'(i_entry_index);
        ram_wdata.kind   = i_entry_type;
        ram_wdata.length = i_entry_length;
        ram_wdata.base   = i_entry_base;
        ram_re           = 1'b0;
        ram_raddr        = r_rd_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_cmd == CMD_LOAD) begin
                        ram_we      = load_in_range;
                        n_out_valid = 1'b1;
                        n_status    = ST_LOADED;
                        n_addr      = '0;
                        n_slot      = '0;
                    end else begin
                        n_state   = S_SCAN;
                        n_size    = i_request_size;
                        n_rd_idx  = '0;
                        n_chk_vld = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state    = S_WRITE;
                    n_old_base = rd_region.base;
                    n_new_len  = add_sum[ADDR_W-1:0];
                end else if (scan_end) begin
                    // last read slot missed, or nothing to scan
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_NOMEM;
                    n_addr      = '0;
                    n_slot      = '0;
                end else begin
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CTR_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx;
                end
            end
            S_WRITE: begin
                ram_we           = 1'b1;
                ram_waddr        = r_chk_idx[IDX_W-1:0];
                ram_wdata.kind   = r_ram_type;
                ram_wdata.length = r_new_len;
                ram_wdata.base   = add_sum[ADDR_W-1:0];
                n_state          = S_IDLE;
                n_out_valid      = 1'b1;
                n_status         = ST_GRANTED;
                n_addr           = r_old_base;
                n_slot           = SLOT_W'(r_chk_idx);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_chk_vld     <= 1'b0;
            r_entry_count <= '0;
            r_ram_type    <= RAM_TYPE_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[CNT_W-1:0];
                    CFG_RAM_TYPE:    r_ram_type    <= i_cfg_data[KIND_W-1:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_chk_idx  <= n_chk_idx;
        r_size     <= n_size;
        r_old_base <= n_old_base;
        r_new_len  <= n_new_len;
        r_status   <= n_status;
        r_addr     <= n_addr;
        r_slot     <= n_slot;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_addr;
    assign o_granted_slot    = r_slot;

    // the slot under compare always lies inside the scan range
    a_chk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_chk_vld) |-> (CMP_W'(r_chk_idx) < limit))
        else $error("compared slot outside scan range");

    // the output slot is empty while an allocation is in flight
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_WRITE) |-> !r_out_valid)
        else $error("result register busy during allocation");

    // write-back is followed by a granted result
    a_write_grants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=>
            (r_state == S_IDLE && r_out_valid && r_status == ST_GRANTED))
        else $error("write-back did not produce a grant");

    // non-grant results carry zero address and slot
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_GRANTED) |->
            (r_addr == '0 && r_slot == '0))
        else $error("non-grant result with nonzero fields");

    // only the three defined status codes reach the output
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_status == ST_LOADED || r_status == ST_GRANTED || r_status == ST_NOMEM))
        else $error("undefined status code");

endmodule

`default_nettype wire
